### hw/rtl/uvsg_pkg.sv
// ----------------------------------------------------------------------------
// uvsg_pkg: shared types and constants for the UV sphere vertex generator
// Stage payload types, the arctangent table and the divider bit step.
// ----------------------------------------------------------------------------
package uvsg_pkg;

  localparam int DIV_STEPS = 32;
  localparam int LAT_SKIP = 2;
  localparam int ROT_STEPS = 20;
  localparam logic signed [32:0] ROT_START = 33'sd652032874;

  localparam logic [1:0] REG_LAT_BANDS = 2'd0;
  localparam logic [1:0] REG_LON_BANDS = 2'd1;

  typedef struct packed {
    logic        err;
    logic [15:0] vn;
    logic [15:0] nrn;
    logic        upper;
    logic        lower;
  } side_t;

  typedef struct packed {
    logic [7:0]  lat_r;
    logic [30:0] lat_q;
    logic        lat_neg;
    logic [7:0]  lng_r;
    logic [31:0] lng_q;
  } div_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic [1:0]         quad;
  } rot_t;

  typedef struct packed {
    rot_t lat;
    rot_t lng;
  } rot_pair_t;

  function automatic logic signed [32:0] atan_turns(input int k);
    logic signed [32:0] a;
    case (k)
      0: a = 33'sd536870912;
      1: a = 33'sd316933406;
      2: a = 33'sd167458907;
      3: a = 33'sd85004756;
      4: a = 33'sd42667331;
      5: a = 33'sd21354465;
      6: a = 33'sd10679838;
      7: a = 33'sd5340245;
      8: a = 33'sd2670163;
      9: a = 33'sd1335087;
      10: a = 33'sd667544;
      11: a = 33'sd333772;
      12: a = 33'sd166886;
      13: a = 33'sd83443;
      14: a = 33'sd41722;
      15: a = 33'sd20861;
      16: a = 33'sd10430;
      17: a = 33'sd5215;
      18: a = 33'sd2608;
      19: a = 33'sd1304;
      default: a = 33'sd0;
    endcase
    return a;
  endfunction

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [8:0] div_bit(input logic [7:0] r, input logic [7:0] d);
    logic [8:0] r2;
    logic [8:0] diff;
    r2 = {r, 1'b0};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      return {1'b1, diff[7:0]};
    end else begin
      return {1'b0, r2[7:0]};
    end
  endfunction

endpackage

### hw/rtl/uvsg_div_cell.sv
// ----------------------------------------------------------------------------
// uvsg_div_cell: one quotient bit of the latitude and longitude phase division
// Shifts a fraction bit into lng_q (and lat_q if LAT_ON); hands on the item.
// ----------------------------------------------------------------------------
module uvsg_div_cell #(
  parameter bit LAT_ON = 1'b1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  uvsg_pkg::side_t in_side,
  input  uvsg_pkg::div_t  in_div,
  input  logic [7:0]    lat_bands,
  input  logic [7:0]    lon_bands,
  output logic          out_valid,
  output uvsg_pkg::side_t out_side,
  output uvsg_pkg::div_t  out_div
);
  import uvsg_pkg::*;

  logic [8:0] lat_step;
  logic [8:0] lng_step;
  div_t       div_next;

  always_comb begin
    lat_step = div_bit(in_div.lat_r, lat_bands);
    lng_step = div_bit(in_div.lng_r, lon_bands);
    div_next = in_div;
    if (LAT_ON) begin
      div_next.lat_r = lat_step[7:0];
      div_next.lat_q = {in_div.lat_q[29:0], lat_step[8]};
    end
    div_next.lng_r = lng_step[7:0];
    div_next.lng_q = {in_div.lng_q[30:0], lng_step[8]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_side <= in_side;
    out_div  <= div_next;
  end

endmodule

### hw/rtl/uvsg_cordic_cell.sv
// ----------------------------------------------------------------------------
// uvsg_cordic_cell: one CORDIC rotation step for both angles
// Rotates the latitude and longitude vectors by the step's arctangent.
// ----------------------------------------------------------------------------
module uvsg_cordic_cell #(
  parameter int K = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  uvsg_pkg::side_t     in_side,
  input  uvsg_pkg::rot_pair_t in_rot,
  output logic                out_valid,
  output uvsg_pkg::side_t     out_side,
  output uvsg_pkg::rot_pair_t out_rot
);
  import uvsg_pkg::*;

  localparam logic signed [32:0] ATAN = atan_turns(K);

  function automatic rot_t rotate(input rot_t v);
    rot_t o;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    dx = v.y >>> K;
    dy = v.x >>> K;
    o = v;
    if (!v.z[32]) begin
      o.x = v.x - dx;
      o.y = v.y + dy;
      o.z = v.z - ATAN;
    end else begin
      o.x = v.x + dx;
      o.y = v.y - dy;
      o.z = v.z + ATAN;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_side    <= in_side;
    out_rot.lat <= rotate(in_rot.lat);
    out_rot.lng <= rotate(in_rot.lng);
  end

endmodule

### hw/rtl/uv_sphere_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_top: UV sphere vertex generator
// Grid point in, position, vertex numbers and triangle flags out.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive lat_row/lon_col and pulse start; the item is taken at an
//   edge with start high and busy low. busy is high only during reset, so
//   one item may enter every cycle.
//   Output: done strobes for one cycle with the result on the result ports.
//   The receiver cannot stall; results must be taken when done is high.
//   Pipeline: entry register, 32 divider cells, phase rounding, 20 CORDIC
//   cells, quadrant fix, multiply, output.
//   Throughput: one item per cycle, set by the cell chain, each cell one
//   stage of the pipeline.
//   Configuration: cfg_we with cfg_index 0 (lat_bands) or 1 (lon_bands);
//   write only while no item is in flight. Other indexes are ignored.
//   Reset: both band counts return to 16 and all items in flight are dropped.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_top #(
  parameter int MAX_BANDS = 255,
  parameter int COORD_FRACTION_BITS = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        lat_row,
  input  logic [7:0]        lon_col,
  output logic              done,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic [15:0]       vertex_number,
  output logic [15:0]       next_row_number,
  output logic              upper_tri_valid,
  output logic              lower_tri_valid,
  output logic              range_error
);
  import uvsg_pkg::*;

  localparam int F = COORD_FRACTION_BITS;
  localparam int XSH = 60 - F;
  localparam int ZSH = 30 - F;
  localparam logic signed [65:0] XRND = (66'sd1 <<< XSH) >>> 1;
  localparam logic signed [32:0] ZRND = (33'sd1 <<< ZSH) >>> 1;
  localparam longint HI_RAW = (64'sd1 <<< F) - 1;
  localparam longint HI = (HI_RAW > 32767) ? 32767 : HI_RAW;
  localparam longint LO = -HI - 1;
  localparam int LATENCY = DIV_STEPS + ROT_STEPS + 5;

  logic [7:0] lat_bands;
  logic [7:0] lon_bands;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_bands <= 8'd16;
      lon_bands <= 8'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAT_BANDS: lat_bands <= cfg_data;
        REG_LON_BANDS: lon_bands <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // Entry stage
  logic       accept;
  logic [8:0] row2;
  logic [8:0] mag;
  logic [16:0] vn_full;
  side_t      side_next;
  div_t       div_next;

  assign accept = start && !busy;

  always_comb begin
    row2 = {lat_row, 1'b0};
    mag = (row2 >= {1'b0, lat_bands}) ? row2 - {1'b0, lat_bands}
                                      : {1'b0, lat_bands} - row2;
    vn_full = 17'(lat_row * ({1'b0, lon_bands} + 9'd1)) + {9'd0, lon_col};
    side_next.err = (lat_bands == 8'd0) || (lon_bands == 8'd0) ||
                    (32'(lat_bands) > MAX_BANDS) || (32'(lon_bands) > MAX_BANDS) ||
                    (lat_row > lat_bands) || (lon_col > lon_bands);
    side_next.vn = vn_full[15:0];
    side_next.nrn = vn_full[15:0] + {8'd0, lon_bands} + 16'd1;
    side_next.upper = (lat_row < lat_bands) && (lon_col < lon_bands) && (lat_row != 8'd0);
    side_next.lower = (lat_row < lat_bands) && (lon_col < lon_bands) &&
                      (lat_row != lat_bands - 8'd1);
    div_next.lat_neg = row2 < {1'b0, lat_bands};
    if (mag == {1'b0, lat_bands}) begin
      div_next.lat_r = 8'd0;
      div_next.lat_q = 31'd1;
    end else begin
      div_next.lat_r = mag[7:0];
      div_next.lat_q = 31'd0;
    end
    if (lon_col == lon_bands) begin
      div_next.lng_r = 8'd0;
      div_next.lng_q = 32'd1;
    end else begin
      div_next.lng_r = lon_col;
      div_next.lng_q = 32'd0;
    end
  end

  logic  dv [0:DIV_STEPS];
  side_t ds [0:DIV_STEPS];
  div_t  dd [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= accept;
    end
    ds[0] <= side_next;
    dd[0] <= div_next;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    uvsg_div_cell #(.LAT_ON(i >= LAT_SKIP)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(dv[i]), .in_side(ds[i]), .in_div(dd[i]),
      .lat_bands(lat_bands), .lon_bands(lon_bands),
      .out_valid(dv[i+1]), .out_side(ds[i+1]), .out_div(dd[i+1])
    );
  end

  // Phase rounding: add one where remainder plus half the divisor reaches it
  logic        lat_corr;
  logic        lng_corr;
  logic [30:0] lat_mag;
  logic [31:0] lat_phase;
  logic [31:0] lng_phase;
  rot_pair_t   rot_next;

  always_comb begin
    lat_corr = ({1'b0, dd[DIV_STEPS].lat_r} + {2'b0, lat_bands[7:1]}) >= {1'b0, lat_bands};
    lng_corr = ({1'b0, dd[DIV_STEPS].lng_r} + {2'b0, lon_bands[7:1]}) >= {1'b0, lon_bands};
    lat_mag = dd[DIV_STEPS].lat_q + {30'd0, lat_corr};
    lat_phase = dd[DIV_STEPS].lat_neg ? 32'd0 - {1'b0, lat_mag} : {1'b0, lat_mag};
    lng_phase = dd[DIV_STEPS].lng_q + {31'd0, lng_corr};
    rot_next.lat.x = ROT_START;
    rot_next.lat.y = 33'sd0;
    rot_next.lat.z = $signed({3'b000, lat_phase[29:0]});
    rot_next.lat.quad = lat_phase[31:30];
    rot_next.lng.x = ROT_START;
    rot_next.lng.y = 33'sd0;
    rot_next.lng.z = $signed({3'b000, lng_phase[29:0]});
    rot_next.lng.quad = lng_phase[31:30];
  end

  logic      cv [0:ROT_STEPS];
  side_t     cs [0:ROT_STEPS];
  rot_pair_t cr [0:ROT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= dv[DIV_STEPS];
    end
    cs[0] <= ds[DIV_STEPS];
    cr[0] <= rot_next;
  end

  for (genvar k = 0; k < ROT_STEPS; k++) begin : g_rot
    uvsg_cordic_cell #(.K(k)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(cv[k]), .in_side(cs[k]), .in_rot(cr[k]),
      .out_valid(cv[k+1]), .out_side(cs[k+1]), .out_rot(cr[k+1])
    );
  end

  // Quadrant fix
  function automatic logic signed [65:0] fold(input rot_t v);
    logic signed [32:0] c;
    logic signed [32:0] s;
    case (v.quad)
      2'd0: begin c = v.x;  s = v.y;  end
      2'd1: begin c = -v.y; s = v.x;  end
      2'd2: begin c = -v.x; s = -v.y; end
      default: begin c = v.y; s = -v.x; end
    endcase
    return {c, s};
  endfunction

  logic               qv;
  side_t              qs;
  logic signed [32:0] clat, slat, clng, slng;

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else begin
      qv <= cv[ROT_STEPS];
    end
    qs <= cs[ROT_STEPS];
    {clat, slat} <= fold(cr[ROT_STEPS].lat);
    {clng, slng} <= fold(cr[ROT_STEPS].lng);
  end

  logic               mv;
  side_t              ms;
  logic signed [65:0] px, py;
  logic signed [32:0] pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else begin
      mv <= qv;
    end
    ms <= qs;
    px <= clng * clat;
    py <= slng * clat;
    pz <= slat;
  end

  function automatic logic [15:0] clamp(input logic signed [65:0] v);
    if (v > 66'(HI)) return 16'(HI);
    if (v < 66'(LO)) return 16'(LO);
    return v[15:0];
  endfunction

  logic signed [65:0] rx, ry, rz;

  always_comb begin
    rx = (px + XRND) >>> XSH;
    ry = (py + XRND) >>> XSH;
    rz = 66'((pz + ZRND) >>> ZSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mv;
    end
    range_error <= ms.err;
    // drop every field of an out-of-range item
    if (ms.err) begin
      pos_x <= 16'sd0;
      pos_y <= 16'sd0;
      pos_z <= 16'sd0;
      vertex_number <= 16'd0;
      next_row_number <= 16'd0;
      upper_tri_valid <= 1'b0;
      lower_tri_valid <= 1'b0;
    end else begin
      pos_x <= clamp(rx);
      pos_y <= clamp(ry);
      pos_z <= clamp(rz);
      vertex_number <= ms.vn;
      next_row_number <= ms.nrn;
      upper_tri_valid <= ms.upper;
      lower_tri_valid <= ms.lower;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without matching item");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (pos_x == 16'sd0 && pos_y == 16'sd0 && pos_z == 16'sd0 &&
                               vertex_number == 16'd0 && !upper_tri_valid))
    else $error("error item carries data");

  a_tri_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (upper_tri_valid || lower_tri_valid)) |-> !range_error)
    else $error("triangle flag on bad item");
`endif

endmodule

### sim/uvsg_checker.sv
// ----------------------------------------------------------------------------
// uvsg_checker: result checker for the UV sphere vertex generator
// Watches accepted grid points and configuration writes, computes the expected
// vertex for each point and compares it with every strobed result.
// ----------------------------------------------------------------------------
module uvsg_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               start,
  input  logic               busy,
  input  logic [7:0]         lat_row,
  input  logic [7:0]         lon_col,
  input  logic               done,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic [15:0]        vertex_number,
  input  logic [15:0]        next_row_number,
  input  logic               upper_tri_valid,
  input  logic               lower_tri_valid,
  input  logic               range_error,
  output int                 fail_count,
  output int                 pending,
  output int                 vertex_count
);
  import uvsg_pkg::*;

  localparam int FRAC = 15;
  localparam int BAND_LIMIT = 255;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [15:0]        vn;
    logic [15:0]        nrn;
    logic               upper;
    logic               lower;
    logic               err;
  } vertex_t;

  vertex_t expected_vertices[$];
  logic [7:0] lat_cfg;
  logic [7:0] lon_cfg;

  function automatic longint floor_sh(longint v, int k);
    return v >>> k;
  endfunction

  function automatic void rotate(logic [31:0] phase, output longint c, output longint s);
    longint x, y, z, dx, dy;
    logic [1:0] quad;
    quad = phase[31:30];
    x = 652032874;
    y = 0;
    z = longint'(phase[29:0]);
    for (int k = 0; k < ROT_STEPS; k++) begin
      dx = floor_sh(y, k);
      dy = floor_sh(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turns(k));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turns(k));
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [15:0] quantize(longint v, int scale);
    int sh;
    longint hi, lo;
    sh = scale - FRAC;
    hi = (longint'(1) << FRAC) - 1;
    lo = -(longint'(1) << FRAC);
    if (sh > 0) v = floor_sh(v + (longint'(1) << (sh - 1)), sh);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic vertex_t grid_vertex(logic [7:0] row, logic [7:0] col,
                                          logic [7:0] nlat, logic [7:0] nlon);
    vertex_t r;
    longint n, mag, q, clat, slat, clng, slng;
    logic [31:0] lat_ph, lng_ph;
    logic [31:0] num;
    r = '{default: '0};
    if (nlat == 0 || nlon == 0 || nlat > BAND_LIMIT || nlon > BAND_LIMIT ||
        row > nlat || col > nlon) begin
      r.err = 1'b1;
      return r;
    end
    n = 2 * longint'(row) - longint'(nlat);
    mag = n < 0 ? -n : n;
    q = ((mag << 30) + nlat / 2) / nlat;
    lat_ph = n < 0 ? 32'(-q) : 32'(q);
    lng_ph = 32'(((longint'(col) << 32) + nlon / 2) / nlon);
    rotate(lat_ph, clat, slat);
    rotate(lng_ph, clng, slng);
    r.x = quantize(clng * clat, 60);
    r.y = quantize(slng * clat, 60);
    r.z = quantize(slat, 30);
    num = 32'(row) * (32'(nlon) + 1) + 32'(col);
    r.vn = num[15:0];
    r.nrn = 16'(num + nlon + 1);
    if (row < nlat && col < nlon) begin
      r.upper = row != 0;
      r.lower = row != nlat - 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    vertex_t e;
    if (rst) begin
      lat_cfg <= 8'd16;
      lon_cfg <= 8'd16;
      expected_vertices.delete();
      fail_count <= 0;
      vertex_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_LAT_BANDS) lat_cfg <= cfg_data;
        else if (cfg_index == REG_LON_BANDS) lon_cfg <= cfg_data;
      end
      if (done) begin
        vertex_count <= vertex_count + 1;
        if (expected_vertices.size() == 0) begin
          $error("result with no item outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_vertices.pop_front();
          if (pos_x !== e.x || pos_y !== e.y || pos_z !== e.z || vertex_number !== e.vn ||
              next_row_number !== e.nrn || upper_tri_valid !== e.upper ||
              lower_tri_valid !== e.lower || range_error !== e.err) begin
            if (pos_x !== e.x) $error("pos_x exp %0d got %0d", e.x, pos_x);
            if (pos_y !== e.y) $error("pos_y exp %0d got %0d", e.y, pos_y);
            if (pos_z !== e.z) $error("pos_z exp %0d got %0d", e.z, pos_z);
            if (vertex_number !== e.vn)
              $error("vertex_number exp %0d got %0d", e.vn, vertex_number);
            if (next_row_number !== e.nrn)
              $error("next_row_number exp %0d got %0d", e.nrn, next_row_number);
            if (upper_tri_valid !== e.upper)
              $error("upper_tri_valid exp %0b got %0b", e.upper, upper_tri_valid);
            if (lower_tri_valid !== e.lower)
              $error("lower_tri_valid exp %0b got %0b", e.lower, lower_tri_valid);
            if (range_error !== e.err)
              $error("range_error exp %0b got %0b", e.err, range_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      // queue the new item after the result check so an early result is caught
      if (start && !busy)
        expected_vertices.insert(expected_vertices.size(),
                                 grid_vertex(lat_row, lon_col, lat_cfg, lon_cfg));
      pending <= expected_vertices.size();
    end
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the UV sphere vertex generator
// Drives directed and random grid points over several band settings with
// random gaps; the checker predicts and compares each vertex.
// ----------------------------------------------------------------------------
module tb_top;
  import uvsg_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_LAT_BANDS;
  logic [7:0] cfg_data = '0;
  logic start = 1'b0;
  logic [7:0] lat_row = '0;
  logic [7:0] lon_col = '0;
  logic busy, done, upper_tri_valid, lower_tri_valid, range_error;
  logic signed [15:0] pos_x, pos_y, pos_z;
  logic [15:0] vertex_number, next_row_number;
  int fail_count, pending, vertex_count;
  int idle_cycles = 0;
  int points_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  uv_sphere_vertex_generator_top uut (.*);

  uvsg_checker checker_i (.*);

  // Watchdog: count cycles with nothing accepted and no result.
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress, %0d results outstanding", pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_point(logic [7:0] row, logic [7:0] col, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    lat_row <= row;
    lon_col <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    points_sent++;
  endtask

  task automatic set_bands(logic [7:0] nlat, logic [7:0] nlon);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_LAT_BANDS;
    cfg_data <= nlat;
    @(negedge clk);
    cfg_index <= REG_LON_BANDS;
    cfg_data <= nlon;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly in-range points, with a few out of range.
  task automatic random_points(int count, logic [7:0] nlat, logic [7:0] nlon);
    logic [7:0] r, c;
    bit gaps;
    gaps = $urandom_range(0, 3) != 0;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        r = 8'($urandom_range(0, 255));
        c = 8'($urandom_range(0, 255));
      end else begin
        r = 8'($urandom_range(0, nlat));
        c = 8'($urandom_range(0, nlon));
      end
      send_point(r, c, gaps);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: poles, seam, corners and out-of-range points at reset bands.
    send_point(0, 0, 0);
    send_point(16, 16, 0);
    send_point(8, 0, 0);
    send_point(8, 4, 0);
    send_point(8, 8, 0);
    send_point(8, 12, 0);
    send_point(15, 15, 0);
    send_point(1, 15, 0);
    send_point(0, 16, 0);
    send_point(17, 0, 0);
    send_point(0, 17, 0);
    send_point(255, 255, 0);

    // Zero band count flags every point.
    set_bands(0, 0);
    send_point(0, 0, 0);
    set_bands(1, 0);
    send_point(0, 0, 0);

    set_bands(1, 1);
    send_point(0, 0, 0);
    send_point(1, 1, 0);
    send_point(0, 1, 0);
    send_point(2, 0, 0);

    set_bands(255, 255);
    send_point(255, 255, 0);
    send_point(254, 254, 0);
    send_point(128, 170, 0);
    send_point(0, 0, 0);
    send_point(127, 85, 0);

    random_points(150, 255, 255);
    set_bands(2, 3);
    random_points(100, 2, 3);
    set_bands(16, 16);
    random_points(150, 16, 16);
    set_bands(7, 200);
    random_points(150, 7, 200);
    set_bands(1, 255);
    random_points(50, 1, 255);
    for (int k = 0; k < 5; k++) begin
      logic [7:0] nl, nn;
      nl = 8'($urandom_range(1, 255));
      nn = 8'($urandom_range(1, 255));
      set_bands(nl, nn);
      random_points(50, nl, nn);
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("checked %0d vertices from %0d points over corner and random band counts",
             vertex_count, points_sent);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/uvsg_pkg.sv
hw/rtl/uvsg_div_cell.sv
hw/rtl/uvsg_cordic_cell.sv
hw/rtl/uv_sphere_vertex_generator_top.sv
sim/uvsg_checker.sv
sim/tb_top.sv
